// File: sv/ole_pkg.sv
package ole_pkg;

   // Command codes carried in the lowest bits of an input transaction
   typedef enum logic [2:0] {
      CMD_APPEND     = 3'd0,
      CMD_DEL_FIRST  = 3'd1,
      CMD_DEL_LAST   = 3'd2,
      CMD_DEL_AT_POS = 3'd3,
      CMD_READ_ALL   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Datapath operation selected by one control word
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_APPEND,
      ACT_DEC,
      ACT_IDX_ZERO,
      ACT_IDX_POS,
      ACT_SHIFT,
      ACT_EMIT_DATA,
      ACT_EMIT_STATUS
   } act_type;

   // Jump condition; when it holds the step counter loads the target, or the command's entry step on dispatch
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_EMPTY,
      COND_FULL,
      COND_BADPOS,
      COND_SHIFT_DONE,
      COND_MORE
   } cond_type;

   // What a step waits for before it acts and moves on
   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_OUT
   } hold_type;

   typedef logic [4:0] step_type;

   localparam step_type S_FETCH     = 5'd0;
   localparam step_type S_APP_CHK   = 5'd1;
   localparam step_type S_APP_DO    = 5'd2;
   localparam step_type S_DF_CHK    = 5'd3;
   localparam step_type S_DF_SET    = 5'd4;
   localparam step_type S_DL_CHK    = 5'd5;
   localparam step_type S_DL_DO     = 5'd6;
   localparam step_type S_DP_CHK    = 5'd7;
   localparam step_type S_DP_POS    = 5'd8;
   localparam step_type S_DP_SET    = 5'd9;
   localparam step_type S_SH_RD     = 5'd10;
   localparam step_type S_SH_WR     = 5'd11;
   localparam step_type S_SH_END    = 5'd12;
   localparam step_type S_RD_CHK    = 5'd13;
   localparam step_type S_RD_SET    = 5'd14;
   localparam step_type S_RD_ADDR   = 5'd15;
   localparam step_type S_RD_EMIT   = 5'd16;
   localparam step_type S_RD_END    = 5'd17;
   localparam step_type S_EM_OK     = 5'd18;
   localparam step_type S_EM_EMPTY  = 5'd19;
   localparam step_type S_EM_BADPOS = 5'd20;
   localparam step_type S_EM_FULL   = 5'd21;

   typedef struct packed {
      act_type    act;
      cond_type   cond;
      hold_type   hold;
      step_type   target;
      status_type status;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{act: ACT_NONE, cond: COND_ALWAYS, hold: HOLD_NONE,
            target: S_FETCH, status: ST_OK};
      unique case (step)
         S_FETCH:     begin w.cond = COND_DISPATCH; w.hold = HOLD_REQ; end
         S_APP_CHK:   begin w.cond = COND_FULL; w.target = S_EM_FULL; end
         S_APP_DO:    begin w.act = ACT_APPEND; w.target = S_EM_OK; end
         S_DF_CHK:    begin w.cond = COND_EMPTY; w.target = S_EM_EMPTY; end
         S_DF_SET:    begin w.act = ACT_IDX_ZERO; w.target = S_SH_RD; end
         S_DL_CHK:    begin w.cond = COND_EMPTY; w.target = S_EM_EMPTY; end
         S_DL_DO:     begin w.act = ACT_DEC; w.target = S_EM_OK; end
         S_DP_CHK:    begin w.cond = COND_EMPTY; w.target = S_EM_EMPTY; end
         S_DP_POS:    begin w.cond = COND_BADPOS; w.target = S_EM_BADPOS; end
         S_DP_SET:    begin w.act = ACT_IDX_POS; w.target = S_SH_RD; end
         // read of entry idx+1 is issued here by the address mux
         S_SH_RD:     begin w.cond = COND_SHIFT_DONE; w.target = S_SH_END; end
         S_SH_WR:     begin w.act = ACT_SHIFT; w.target = S_SH_RD; end
         S_SH_END:    begin w.act = ACT_DEC; w.target = S_EM_OK; end
         S_RD_CHK:    begin w.cond = COND_EMPTY; w.target = S_EM_EMPTY; end
         S_RD_SET:    begin w.act = ACT_IDX_ZERO; w.cond = COND_NEVER; end
         S_RD_ADDR:   begin w.cond = COND_NEVER; end
         S_RD_EMIT:   begin
            w.act = ACT_EMIT_DATA; w.cond = COND_MORE; w.hold = HOLD_OUT;
            w.target = S_RD_ADDR;
         end
         S_RD_END:    begin w.target = S_FETCH; end
         S_EM_OK:     begin
            w.act = ACT_EMIT_STATUS; w.hold = HOLD_OUT; w.status = ST_OK;
         end
         S_EM_EMPTY:  begin
            w.act = ACT_EMIT_STATUS; w.hold = HOLD_OUT; w.status = ST_EMPTY;
         end
         S_EM_BADPOS: begin
            w.act = ACT_EMIT_STATUS; w.hold = HOLD_OUT; w.status = ST_BADPOS;
         end
         S_EM_FULL:   begin
            w.act = ACT_EMIT_STATUS; w.hold = HOLD_OUT; w.status = ST_FULL;
         end
         default:     begin w.target = S_FETCH; end
      endcase
      return w;
   endfunction

   // Entry point of each command's routine
   function automatic step_type dispatch(input logic [2:0] cmd);
      step_type s;
      unique case (cmd)
         CMD_APPEND:     s = S_APP_CHK;
         CMD_DEL_FIRST:  s = S_DF_CHK;
         CMD_DEL_LAST:   s = S_DL_CHK;
         CMD_DEL_AT_POS: s = S_DP_CHK;
         CMD_READ_ALL:   s = S_RD_CHK;
         default:        s = S_EM_BADPOS;
      endcase
      return s;
   endfunction

endpackage

// File: sv/ole_store.sv
// Entry store: one write port, one read port with registered read data.
module ole_store #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ordered_list_engine.sv
// Ordered list engine: a bounded list of signed 32-bit values kept in order.
// Request channel (req_*): one transaction carries a command, a value for
// append and a 1-based position for delete-at-position. Response channel
// (rsp_*): every command except read-all gives one status transaction with
// tdata zero and tlast high. Read-all gives one transaction per entry, head
// first, status ok and tlast on the tail, or a single empty status.
// Commands run one at a time under a small microprogram; req_tready is high
// only while the sequencer sits in its fetch step.
// Delete first and delete at position move every later entry down by one,
// each moved entry needing a read then a write through the store.
// A result sits in the response register until taken; the sequencer stalls
// at its next emit step while it is occupied, but may already fetch the
// next command after the final result of the current one.
// Reset (synchronous, active high) empties the list and drops any pending
// response; the store contents are not cleared and need no sweep.
module ordered_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [2:0] command, [34:3] value, [42:35] position
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   // sequencer state
   ole_pkg::step_type  step_ff, step_in;
   ole_pkg::ucode_type uw;

   // datapath registers
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   value_ff, value_in;
   logic [7:0]    pos_ff, pos_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   // store port
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [IW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic          out_free;
   logic          go;
   logic          cond_hit;
   logic [CW-1:0] idx_next;

   ole_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign uw       = ole_pkg::ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_next = CW'(idx_ff) + CW'(1);

   // a step acts and moves on only once what it waits for is there
   always_comb begin
      unique case (uw.hold)
         ole_pkg::HOLD_REQ: go = req_tvalid;
         ole_pkg::HOLD_OUT: go = out_free;
         default:           go = 1'b1;
      endcase
   end

   always_comb begin
      unique case (uw.cond)
         ole_pkg::COND_ALWAYS:     cond_hit = 1'b1;
         ole_pkg::COND_DISPATCH:   cond_hit = 1'b1;
         ole_pkg::COND_EMPTY:      cond_hit = (count_ff == '0);
         ole_pkg::COND_FULL:       cond_hit = (count_ff == CW'(CAPACITY));
         ole_pkg::COND_BADPOS:     cond_hit = (pos_ff == 8'd0) ||
                                              (pos_ff > 8'(count_ff));
         ole_pkg::COND_SHIFT_DONE: cond_hit = (idx_next >= count_ff);
         ole_pkg::COND_MORE:       cond_hit = (idx_next != count_ff);
         default:                  cond_hit = 1'b0;
      endcase
   end

   // step counter
   always_comb begin
      step_in = step_ff;
      if (go) begin
         if (uw.cond == ole_pkg::COND_DISPATCH) begin
            step_in = ole_pkg::dispatch(req_tdata[2:0]);
         end else if (cond_hit) begin
            step_in = uw.target;
         end else begin
            step_in = step_ff + ole_pkg::step_type'(1);
         end
      end
   end

   assign req_tready = (uw.hold == ole_pkg::HOLD_REQ);

   // datapath
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      // the shift loop reads one entry ahead; otherwise the read follows idx
      rd_addr       = (step_ff == ole_pkg::S_SH_RD) ? IW'(idx_next) : idx_ff;

      if (go && uw.hold == ole_pkg::HOLD_REQ) begin
         value_in = req_tdata[34:3];
         pos_in   = req_tdata[42:35];
      end

      if (go) begin
         case (uw.act)
            ole_pkg::ACT_APPEND: begin
               wr_en    = 1'b1;
               wr_addr  = IW'(count_ff);
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
            end
            ole_pkg::ACT_DEC: begin
               count_in = count_ff - CW'(1);
            end
            ole_pkg::ACT_IDX_ZERO: begin
               idx_in = '0;
            end
            ole_pkg::ACT_IDX_POS: begin
               idx_in = IW'(pos_ff - 8'd1);
            end
            ole_pkg::ACT_SHIFT: begin
               // close the gap: entry idx+1 moves down to idx
               wr_en  = 1'b1;
               idx_in = IW'(idx_next);
            end
            ole_pkg::ACT_EMIT_DATA: begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_data;
               rsp_status_in = ole_pkg::ST_OK;
               rsp_last_in   = (idx_next == count_ff);
               idx_in        = IW'(idx_next);
            end
            ole_pkg::ACT_EMIT_STATUS: begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = uw.status;
               rsp_last_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ole_pkg::S_FETCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CW'(1)) ||
                        (count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ole_pkg::S_SH_WR) |-> (idx_next < count_ff))
      else $error("shift reads beyond the list tail");
`endif

endmodule
